[rtl/lrg_pkg.sv]
package lrg_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned WordW  = 64;
  localparam int unsigned BoundW = 31;
  localparam int unsigned StateW = 2 * WordW;
  localparam int unsigned LimbW  = 32;

  // Command codes
  localparam logic [CmdW-1:0] CMD_RAW     = 3'd0;
  localparam logic [CmdW-1:0] CMD_BOUNDED = 3'd1;
  localparam logic [CmdW-1:0] CMD_RESEED  = 3'd2;
  localparam logic [CmdW-1:0] CMD_RANK    = 3'd3;
  localparam logic [CmdW-1:0] CMD_DERIVE  = 3'd4;

  // Generator multiplier, high:low
  localparam logic [StateW-1:0] LCG_MULT = 128'h12e15e35b500f16e_2e714eb2b37916a5;

  localparam logic [WordW-1:0] GOLDEN   = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] DERIVE_K = 64'hD1B54A32D192ED03;
  localparam logic [WordW-1:0] MIX_C1   = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] MIX_C2   = 64'h94D049BB133111EB;

endpackage

[rtl/lrg_in_if.sv]
interface lrg_in_if;
  import lrg_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [WordW-1:0]  operand;
  logic [BoundW-1:0] bound;

  modport source (output valid, output command, output operand, output bound, input ready);
  modport sink   (input valid, input command, input operand, input bound, output ready);

endinterface

[rtl/lrg_out_if.sv]
interface lrg_out_if;
  import lrg_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

[rtl/lehmer128_random_generator.sv]
// 128-bit multiplicative congruential random generator.
// Input channel in_i carries a command, a 64-bit operand and a 31-bit bound;
// output channel out_o carries one 64-bit value for raw draw, bounded draw
// and derive commands. Reseed commands and unknown codes give no item.
// One item is worked at a time; in_i.ready is high only while idle.
// All products go through one 32x32 multiplier: each partial product is
// first multiplied into a register and then shifted and added into the
// accumulator, for 64-bit products and the 128-bit state update alike.
// A raw draw first seeds the state from the master when the state is
// still zero; a bounded draw adds a bit-serial remainder after the draw;
// a derive runs its mix through the multiplier; a rank reseed keeps the
// block busy through its mixing, while a direct reseed leaves it idle.
// Reset sets the state to zero (seeded on the first draw) and the master
// seed to one. A finished value sits in an output register; the block
// accepts the next item while it waits, and stalls only when a second
// value is ready before the first has been taken.
module lehmer128_random_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrg_in_if.sink    in_i,
  lrg_out_if.source out_o
);
  import lrg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DRAW = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [3:0] U_LZ1  = 4'd0;
  localparam logic [3:0] U_LZ2  = 4'd1;
  localparam logic [3:0] U_DRAW = 4'd2;
  localparam logic [3:0] U_RK0  = 4'd3;
  localparam logic [3:0] U_RK1  = 4'd4;
  localparam logic [3:0] U_RK2  = 4'd5;
  localparam logic [3:0] U_RK3  = 4'd6;
  localparam logic [3:0] U_RK4  = 4'd7;
  localparam logic [3:0] U_DV0  = 4'd8;
  localparam logic [3:0] U_DV1  = 4'd9;
  localparam logic [3:0] U_DV2  = 4'd10;

  localparam int unsigned CntW = $clog2(WordW);
  localparam logic [CntW-1:0] DivLast = CntW'(WordW - 1);

  function automatic logic [WordW-1:0] xs30(input logic [WordW-1:0] z);
    return z ^ (z >> 30);
  endfunction

  function automatic logic [WordW-1:0] xs27(input logic [WordW-1:0] z);
    return z ^ (z >> 27);
  endfunction

  function automatic logic [WordW-1:0] xs31(input logic [WordW-1:0] z);
    return z ^ (z >> 31);
  endfunction

  function automatic logic [StateW-1:0] load_odd(input logic [WordW-1:0] s);
    return {63'd0, s, 1'b1};
  endfunction

  logic [2:0]        fsm_q, fsm_d;
  logic [3:0]        uop_q, uop_d;
  logic              bounded_q, bounded_d;
  logic [BoundW-1:0] bound_q, bound_d;
  logic [WordW-1:0]  gh_q, gh_d, gl_q, gl_d, master_q, master_d;
  logic [StateW-1:0] ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [1:0]        lim_q, lim_d, i_q, i_d, j_q, j_d, sh_q, sh_d;
  logic              ph_q, ph_d;
  logic [WordW-1:0]  prod_q, prod_d, res_q, res_d, div_q, div_d;
  logic [BoundW-1:0] rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_value_q, out_value_d;

  logic              mul_go, mul_wide, load_out;
  logic [StateW-1:0] mul_a, mul_b, pp_shift;
  logic [3:0]        mul_uop;
  logic [LimbW-1:0]  a_limb, b_limb;
  logic [2:0]        ij_sum;
  logic [WordW-1:0]  acc64, mix_out;
  logic [BoundW:0]   rem_try, rem_sub;
  logic              rem_ge;
  logic [BoundW-1:0] rem_next;

  assign acc64   = acc_q[WordW-1:0];
  assign mix_out = xs31(acc64);
  assign a_limb  = ma_q[{i_q, 5'd0} +: LimbW];
  assign b_limb  = mb_q[{j_q, 5'd0} +: LimbW];
  assign ij_sum  = {1'b0, i_q} + {1'b0, j_q};

  assign rem_try  = {rem_q, div_q[WordW-1]};
  assign rem_sub  = rem_try - {1'b0, bound_q};
  assign rem_ge   = (rem_try >= {1'b0, bound_q});
  assign rem_next = rem_ge ? rem_sub[BoundW-1:0] : rem_try[BoundW-1:0];

  always_comb begin
    unique case (sh_q)
      2'd0: pp_shift = {64'd0, prod_q};
      2'd1: pp_shift = {32'd0, prod_q, 32'd0};
      2'd2: pp_shift = {prod_q, 64'd0};
      2'd3: pp_shift = {prod_q[LimbW-1:0], 96'd0};
    endcase
  end

  always_comb begin
    fsm_d       = fsm_q;
    uop_d       = uop_q;
    bounded_d   = bounded_q;
    bound_d     = bound_q;
    gh_d        = gh_q;
    gl_d        = gl_q;
    master_d    = master_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    acc_d       = acc_q;
    lim_d       = lim_q;
    i_d         = i_q;
    j_d         = j_q;
    sh_d        = sh_q;
    ph_d        = ph_q;
    prod_d      = prod_q;
    res_d       = res_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_value_d = out_value_q;
    mul_go      = 1'b0;
    mul_wide    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    mul_uop     = uop_q;
    load_out    = 1'b0;

    unique case (fsm_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.command)
            CMD_RAW, CMD_BOUNDED: begin
              fsm_d     = S_DRAW;
              bounded_d = (in_i.command == CMD_BOUNDED);
              bound_d   = in_i.bound;
            end
            CMD_RESEED: begin
              master_d     = (in_i.operand == '0) ? 64'd1 : in_i.operand;
              {gh_d, gl_d} = load_odd(in_i.operand);
            end
            CMD_RANK: begin
              mul_go  = 1'b1;
              mul_a   = {64'd0, in_i.operand};
              mul_b   = {64'd0, GOLDEN};
              mul_uop = U_RK0;
            end
            CMD_DERIVE: begin
              mul_go  = 1'b1;
              mul_a   = {64'd0, in_i.operand};
              mul_b   = {64'd0, DERIVE_K};
              mul_uop = U_DV0;
            end
            default: ;
          endcase
        end
      end
      S_DRAW: begin
        mul_go = 1'b1;
        if ({gh_q, gl_q} == '0) begin
          // seed an all-zero state from the master first
          mul_a   = {64'd0, xs30(master_q + 64'd1 + GOLDEN)};
          mul_b   = {64'd0, MIX_C1};
          mul_uop = U_LZ1;
        end else begin
          res_d    = gh_q;
          mul_a    = {gh_q, gl_q};
          mul_b    = LCG_MULT;
          mul_wide = 1'b1;
          mul_uop  = U_DRAW;
        end
      end
      S_MUL: begin
        if (!ph_q) begin
          prod_d = {32'd0, a_limb} * {32'd0, b_limb};
          sh_d   = i_q + j_q;
          ph_d   = 1'b1;
        end else begin
          acc_d = acc_q + pp_shift;
          ph_d  = 1'b0;
          // walk the limb pairs whose product lands below the result width
          if (ij_sum == {1'b0, lim_q}) begin
            if (i_q == lim_q) begin
              fsm_d = S_POST;
            end else begin
              i_d = i_q + 2'd1;
              j_d = 2'd0;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end
      end
      S_POST: begin
        unique case (uop_q)
          U_LZ1, U_RK1, U_RK3, U_DV1: begin
            mul_go  = 1'b1;
            mul_a   = {64'd0, xs27(acc64)};
            mul_b   = {64'd0, MIX_C2};
            mul_uop = uop_q + 4'd1;
          end
          U_LZ2: begin
            {gh_d, gl_d} = load_odd(mix_out);
            fsm_d        = S_DRAW;
          end
          U_DRAW: begin
            gh_d = acc_q[StateW-1:WordW];
            gl_d = acc_q[WordW-1:0];
            if (!bounded_q) begin
              fsm_d = S_DONE;
            end else if (bound_q == '0) begin
              res_d = '0;
              fsm_d = S_DONE;
            end else begin
              div_d = res_q;
              rem_d = '0;
              cnt_d = '0;
              fsm_d = S_DIV;
            end
          end
          U_RK0, U_DV0: begin
            mul_go  = 1'b1;
            mul_a   = {64'd0, xs30((master_q ^ acc64) + GOLDEN)};
            mul_b   = {64'd0, MIX_C1};
            mul_uop = uop_q + 4'd1;
          end
          U_RK2: begin
            master_d = mix_out | 64'd1;
            mul_go   = 1'b1;
            mul_a    = {64'd0, xs30(mix_out + 64'd1 + GOLDEN)};
            mul_b    = {64'd0, MIX_C1};
            mul_uop  = U_RK3;
          end
          U_RK4: begin
            {gh_d, gl_d} = load_odd(mix_out);
            fsm_d        = S_IDLE;
          end
          U_DV2: begin
            res_d = mix_out;
            fsm_d = S_DONE;
          end
          default: fsm_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        rem_d = rem_next;
        div_d = {div_q[WordW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          res_d = {{(WordW-BoundW){1'b0}}, rem_next};
          fsm_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free or being emptied
        if (!out_valid_q || out_o.ready) begin
          load_out    = 1'b1;
          out_value_d = res_q;
          fsm_d       = S_IDLE;
        end
      end
      default: fsm_d = S_IDLE;
    endcase

    if (mul_go) begin
      ma_d  = mul_a;
      mb_d  = mul_b;
      lim_d = mul_wide ? 2'd3 : 2'd1;
      i_d   = 2'd0;
      j_d   = 2'd0;
      ph_d  = 1'b0;
      acc_d = '0;
      uop_d = mul_uop;
      fsm_d = S_MUL;
    end

    out_valid_d = (out_valid_q && !out_o.ready) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      gh_q        <= '0;
      gl_q        <= '0;
      master_q    <= 64'd1;
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
      gh_q        <= gh_d;
      gl_q        <= gl_d;
      master_q    <= master_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uop_q       <= uop_d;
    bounded_q   <= bounded_d;
    bound_q     <= bound_d;
    ma_q        <= ma_d;
    mb_q        <= mb_d;
    acc_q       <= acc_d;
    lim_q       <= lim_d;
    i_q         <= i_d;
    j_q         <= j_d;
    sh_q        <= sh_d;
    ph_q        <= ph_d;
    prod_q      <= prod_d;
    res_q       <= res_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    out_value_q <= out_value_d;
  end

  assign in_i.ready  = (fsm_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

  a_master_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    master_q != '0)
    else $error("master seed became zero");

  a_draw_keeps_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_POST && uop_q == U_DRAW) |=> gl_q[0])
    else $error("state even after a draw");

  a_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_DIV) |-> (rem_q < bound_q))
    else $error("partial remainder not below bound");

  a_pair_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_MUL) |-> (ij_sum <= {1'b0, lim_q}))
    else $error("limb pair beyond result width");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fsm_q == S_DONE))
    else $error("output loaded outside done state");

endmodule

[dv/lrg_checker.sv]
`timescale 1ns / 1ps

module lrg_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lrg_in_if    in_ch,
  lrg_out_if   out_ch,
  output int   errors_o,
  output int   pending_o
);
  import lrg_pkg::*;

  logic [StateW-1:0] gen_state;
  logic [WordW-1:0]  master;
  logic [WordW-1:0]  expected_values[$];
  int                err_count = 0;

  function automatic logic [WordW-1:0] splitmix(input logic [WordW-1:0] x);
    logic [WordW-1:0] z;
    z = x + GOLDEN;
    z = (z ^ (z >> 30)) * MIX_C1;
    z = (z ^ (z >> 27)) * MIX_C2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [StateW-1:0] odd_state(input logic [WordW-1:0] s);
    return {{(WordW-1){1'b0}}, s, 1'b1};
  endfunction

  // Return the high half, then advance the state; seed a zero state from the master.
  function automatic logic [WordW-1:0] next_lehmer_word();
    logic [WordW-1:0] hi;
    if (gen_state == '0) gen_state = odd_state(splitmix(master + 64'd1));
    hi = gen_state[StateW-1:WordW];
    gen_state = gen_state * LCG_MULT;
    return hi;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WordW-1:0] want;
    logic [WordW-1:0] word;
    logic [WordW-1:0] mixed;
    if (!rst_ni) begin
      gen_state = '0;
      master    = 64'd1;
      expected_values.delete();
      err_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Compare before predicting: an item accepted now cannot already be out.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_values.size() == 0) begin
          $display("%0t unexpected value: expected none, actual %h", $time, out_ch.value);
          err_count++;
        end else begin
          want = expected_values.pop_front();
          if (want !== out_ch.value) begin
            $display("%0t value mismatch: expected %h, actual %h", $time, want, out_ch.value);
            err_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          CMD_RAW: expected_values.push_back(next_lehmer_word());
          CMD_BOUNDED: begin
            word = next_lehmer_word();
            if (in_ch.bound == '0) expected_values.push_back('0);
            else expected_values.push_back(word % {{(WordW-BoundW){1'b0}}, in_ch.bound});
          end
          CMD_RESEED: begin
            master    = (in_ch.operand == '0) ? 64'd1 : in_ch.operand;
            gen_state = odd_state(in_ch.operand);
          end
          CMD_RANK: begin
            word      = in_ch.operand * GOLDEN;
            mixed     = splitmix(master ^ word);
            master    = mixed | 64'd1;
            gen_state = odd_state(splitmix(mixed + 64'd1));
          end
          CMD_DERIVE: begin
            word = in_ch.operand * DERIVE_K;
            expected_values.push_back(splitmix(master ^ word));
          end
          default: ;  // unused codes: drop
        endcase
      end
      errors_o  <= err_count;
      pending_o <= expected_values.size();
    end
  end

endmodule

[dv/tb_lehmer128_random_generator.sv]
`timescale 1ns / 1ps

module tb_lehmer128_random_generator;
  import lrg_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 150;
  localparam logic [CmdW-1:0] CMD_UNUSED_FIRST = CMD_DERIVE + 3'd1;
  localparam logic [CmdW-1:0] CMD_UNUSED_LAST  = {CmdW{1'b1}};
  localparam logic [WordW-1:0]  OPERAND_MAX = {WordW{1'b1}};
  localparam logic [BoundW-1:0] BOUND_MAX   = {BoundW{1'b1}};

  logic        clk_i;
  logic        rst_ni;
  int          errors;
  int          pending;
  int          src_idle;
  int          snk_idle;
  logic        hold_tog;
  int unsigned cycles;

  lrg_in_if  in_ch ();
  lrg_out_if out_ch ();

  lehmer128_random_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lrg_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    logic hold_seen;
    hold_seen    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        repeat (HoldCycles) begin
          out_ch.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  task automatic offer_command(input logic [CmdW-1:0] cmd, input logic [WordW-1:0] op,
                               input logic [BoundW-1:0] bnd);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.operand <= op;
    in_ch.bound   <= bnd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Hold the input until every predicted value has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [WordW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return OPERAND_MAX;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [BoundW-1:0] pick_bound();
    logic [BoundW-1:0] b;
    case ($urandom_range(0, 9))
      0:       b = '0;
      1:       b = BOUND_MAX;
      2, 3, 4: b = BoundW'($urandom_range(1, 16));
      5:       b = 31'd1 << $urandom_range(0, BoundW - 1);
      default: b = BoundW'($urandom);
    endcase
    return b;
  endfunction

  task automatic send_random_item(output bit counted);
    int unsigned r;
    logic [CmdW-1:0] cmd;
    r       = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 35) cmd = CMD_RAW;
    else if (r < 65) cmd = CMD_BOUNDED;
    else if (r < 75) cmd = CMD_DERIVE;
    else if (r < 83) cmd = CMD_RESEED;
    else if (r < 90) cmd = CMD_RANK;
    else begin
      cmd     = CmdW'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      counted = 1'b0;
    end
    offer_command(cmd, pick_operand(), pick_bound());
  endtask

  initial begin
    int unsigned sent;
    bit counted;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_RAW;
    in_ch.operand  = '0;
    in_ch.bound    = '0;
    hold_tog       = 1'b0;
    src_idle       = 17;
    snk_idle       = 47;
    sent           = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First draw seeds the zero state from the master.
    offer_command(CMD_RAW, '0, '0);
    offer_command(CMD_RAW, OPERAND_MAX, BOUND_MAX);
    offer_command(CMD_BOUNDED, '0, '0);
    offer_command(CMD_BOUNDED, '0, 31'd1);
    offer_command(CMD_BOUNDED, '0, BOUND_MAX);
    offer_command(CMD_BOUNDED, '0, 31'd7);
    offer_command(CMD_DERIVE, '0, '0);
    offer_command(CMD_DERIVE, OPERAND_MAX, '0);
    // Zero seed falls back to a master of one.
    offer_command(CMD_RESEED, '0, '0);
    offer_command(CMD_RAW, '0, '0);
    offer_command(CMD_DERIVE, 64'd5, '0);
    offer_command(CMD_RAW, '0, '0);
    offer_command(CMD_RESEED, OPERAND_MAX, '0);
    offer_command(CMD_RAW, '0, '0);
    offer_command(CMD_BOUNDED, '0, BOUND_MAX);
    offer_command(CMD_RANK, '0, '0);
    offer_command(CMD_RAW, '0, '0);
    offer_command(CMD_RANK, OPERAND_MAX, '0);
    offer_command(CMD_BOUNDED, '0, 31'd3);
    offer_command(CMD_DERIVE, 64'h8000_0000_0000_0001, '0);
    for (int k = CMD_UNUSED_FIRST; k <= CMD_UNUSED_LAST; k++) begin
      offer_command(CmdW'(k), OPERAND_MAX, BOUND_MAX);
    end
    offer_command(CMD_RAW, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      src_idle <= (phase == 0) ? 17 : (phase == 1) ? 47 : 0;
      snk_idle <= (phase == 0) ? 47 : (phase == 1) ? 17 : 0;
      if (phase == 2) begin
        // Long receiver hold-off while draws keep coming: block must back up.
        hold_tog <= ~hold_tog;
        repeat (40) begin
          offer_command(CMD_RAW, pick_operand(), pick_bound());
          sent++;
        end
      end
      while (sent < RandomItems * (phase + 1) / 3) begin
        send_random_item(counted);
        if (counted) sent++;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
